[rtl/srs_pkg.sv]
package srs_pkg;

   // Result kinds on the rsp channel.
   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_RTT    = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // Register map: byte address 4*index, decoded from paddr[3:2].
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [1:0] REG_TOTAL_FRAMES = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_MS   = 2'd2;

   // Largest RTT sample that fits the output field.
   localparam logic [15:0] RTT_MAX = 16'hFFFF;

   // Configuration as seen by the controller.
   typedef struct packed {
      logic [3:0]  window_size;
      logic [15:0] total_frames;
      logic [15:0] timeout_ms;
   } srs_cfg_type;

   // One result word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] frame_index;
      logic [15:0] rtt_ms;
      logic        last;
   } srs_word_type;

   // Controller to output stage.
   typedef struct packed {
      logic         push;
      logic         flush;
      srs_word_type word;
   } srs_cmd_type;

   // Output stage to controller.
   typedef struct packed {
      logic room;
   } srs_ostat_type;

endpackage

[rtl/srs_ram.sv]
module srs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/srs_out.sv]
module srs_out (
   input  logic                  clock,
   input  logic                  reset,
   input  srs_pkg::srs_cmd_type  cmd,
   output srs_pkg::srs_ostat_type ostat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srs_pkg::srs_word_type rsp_word
);

   import srs_pkg::*;

   srs_word_type pend_ff, pend_in;
   logic         pend_valid_ff, pend_valid_in;
   srs_word_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_free;
   logic         room;

   // The newest result waits in the pending register until the next one
   // arrives or the item ends, so that its last flag is known when it moves on.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign room     = !pend_valid_ff || out_free;

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      if (cmd.push && room) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_in.last  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = cmd.word;
         pend_valid_in = 1'b1;
      end else if (cmd.flush && pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign ostat.room    = room;
   assign rsp_valid     = out_valid_ff;
   assign rsp_word      = out_ff;

endmodule

[rtl/srs_ctrl.sv]
module srs_ctrl #(
   parameter int unsigned WINDOW_MAX = 8,
   parameter int unsigned TIME_BITS  = 32,
   localparam int unsigned SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int unsigned KW = $clog2(WINDOW_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [15:0]            req_ack_index,
   input  srs_pkg::srs_cfg_type   cfg,
   output srs_pkg::srs_cmd_type   cmd,
   input  srs_pkg::srs_ostat_type ostat,
   output logic                   ram_wr_en,
   output logic [SW-1:0]          ram_wr_addr,
   output logic [TIME_BITS-1:0]   ram_wr_data,
   output logic                   ram_rd_en,
   output logic [SW-1:0]          ram_rd_addr,
   input  logic [TIME_BITS-1:0]   ram_rd_data
);

   import srs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_ISSUE,
      ST_TICK_EVAL,
      ST_ACK,
      ST_ACK_EVAL,
      ST_SLIDE,
      ST_FILL,
      ST_DONE_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic                    done_sent_ff, done_sent_in;
   logic [15:0]             ack_ff, ack_in;
   logic [15:0]             base_ff, base_in;
   logic [15:0]             next_ff, next_in;
   logic [SW-1:0]           base_slot_ff, base_slot_in;
   logic [SW-1:0]           next_slot_ff, next_slot_in;
   logic [SW-1:0]           scan_slot_ff, scan_slot_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [WINDOW_MAX-1:0]   acked_ff, acked_in;
   logic [WINDOW_MAX-1:0]   resent_ff, resent_in;

   logic [15:0]             outstanding;
   logic [15:0]             eff_window;
   logic [15:0]             ack_off;
   logic                    ack_in_window;
   logic [SW:0]             ack_sum;
   logic [SW-1:0]           ack_slot;
   logic [SW-1:0]           look_slot;
   logic                    acked_look;
   logic                    resent_look;
   logic [TIME_BITS-1:0]    elapsed;
   logic [15:0]             rtt_sat;

   // Slot pointers advance modulo the window depth.
   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      if (s == SW'(WINDOW_MAX - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // Window bookkeeping.
   assign outstanding = next_ff - base_ff;
   always_comb begin
      if (cfg.window_size == 4'd0) begin
         eff_window = 16'd1;
      end else if (16'(cfg.window_size) > 16'(WINDOW_MAX)) begin
         eff_window = 16'(WINDOW_MAX);
      end else begin
         eff_window = 16'(cfg.window_size);
      end
   end

   // The acknowledged frame's slot is the base slot plus its offset, which is
   // below the window depth whenever the frame is outstanding.
   assign ack_off       = ack_ff - base_ff;
   assign ack_in_window = ack_off < outstanding;
   assign ack_sum       = {1'b0, base_slot_ff} + {1'b0, ack_off[SW-1:0]};
   assign ack_slot      = (ack_sum >= (SW+1)'(WINDOW_MAX)) ?
                          SW'(ack_sum - (SW+1)'(WINDOW_MAX)) : ack_sum[SW-1:0];

   // One slot of flags is looked at per cycle; the state picks which.
   always_comb begin
      case (state_ff)
         ST_ACK:   look_slot = ack_slot;
         ST_SLIDE: look_slot = base_slot_ff;
         default:  look_slot = scan_slot_ff;
      endcase
   end
   assign acked_look  = acked_ff[look_slot];
   assign resent_look = resent_ff[look_slot];

   // Age of the slot's send time, and its saturated form for RTT samples.
   assign elapsed = time_ff - ram_rd_data;
   assign rtt_sat = (elapsed > TIME_BITS'(RTT_MAX)) ? RTT_MAX : elapsed[15:0];

   assign req_stall   = (state_ff != ST_IDLE);
   assign ram_rd_addr = look_slot;
   assign ram_wr_data = time_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      done_sent_in = done_sent_ff;
      ack_in       = ack_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      scan_slot_in = scan_slot_ff;
      k_in         = k_ff;
      time_in      = time_ff;
      acked_in     = acked_ff;
      resent_in    = resent_ff;
      cmd          = '0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = next_slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_mode) begin
                  time_in      = time_ff + 1'b1;
                  k_in         = '0;
                  scan_slot_in = base_slot_ff;
                  state_in     = ST_TICK_ISSUE;
               end else begin
                  ack_in   = req_ack_index;
                  state_in = ST_ACK;
               end
            end
         end

         // Walk the outstanding slots from the base; acked ones are skipped.
         ST_TICK_ISSUE: begin
            if (16'(k_ff) < outstanding) begin
               if (acked_look) begin
                  k_in         = k_ff + 1'b1;
                  scan_slot_in = slot_inc(scan_slot_ff);
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_TICK_EVAL;
               end
            end else begin
               state_in = ST_FILL;
            end
         end

         // Expired frame: resend it and restamp its send time.
         ST_TICK_EVAL: begin
            if (elapsed >= TIME_BITS'(cfg.timeout_ms)) begin
               if (ostat.room) begin
                  cmd.push             = 1'b1;
                  cmd.word.kind        = KIND_RESEND;
                  cmd.word.frame_index = base_ff + 16'(k_ff);
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = scan_slot_ff;
                  resent_in[scan_slot_ff] = 1'b1;
                  k_in                 = k_ff + 1'b1;
                  scan_slot_in         = slot_inc(scan_slot_ff);
                  state_in             = ST_TICK_ISSUE;
               end
            end else begin
               k_in         = k_ff + 1'b1;
               scan_slot_in = slot_inc(scan_slot_ff);
               state_in     = ST_TICK_ISSUE;
            end
         end

         // A fresh acknowledgement inside the window marks its slot.
         ST_ACK: begin
            if (ack_in_window && !acked_look) begin
               acked_in[ack_slot] = 1'b1;
               if (!resent_look) begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_ACK_EVAL;
               end else begin
                  state_in = ST_SLIDE;
               end
            end else begin
               state_in = ST_FILL;
            end
         end

         // Frame never resent: its round trip is a valid sample.
         ST_ACK_EVAL: begin
            if (ostat.room) begin
               cmd.push             = 1'b1;
               cmd.word.kind        = KIND_RTT;
               cmd.word.frame_index = ack_ff;
               cmd.word.rtt_ms      = rtt_sat;
               state_in             = ST_SLIDE;
            end
         end

         // Move the base past acknowledged frames, one per cycle.
         ST_SLIDE: begin
            if ((base_ff < cfg.total_frames) && (base_ff != next_ff) && acked_look) begin
               base_in      = base_ff + 16'd1;
               base_slot_in = slot_inc(base_slot_ff);
            end else begin
               state_in = ST_FILL;
            end
         end

         // Refill the window with new frames, one per cycle while the output stage has room.
         ST_FILL: begin
            if ((next_ff < cfg.total_frames) && (outstanding < eff_window)) begin
               if (ostat.room) begin
                  cmd.push             = 1'b1;
                  cmd.word.kind        = KIND_SEND;
                  cmd.word.frame_index = next_ff;
                  ram_wr_en            = 1'b1;
                  acked_in[next_slot_ff]  = 1'b0;
                  resent_in[next_slot_ff] = 1'b0;
                  next_in              = next_ff + 16'd1;
                  next_slot_in         = slot_inc(next_slot_ff);
               end
            end else begin
               done_sent_in = 1'b0;
               state_in     = ST_DONE_FLUSH;
            end
         end

         // Completion word if due, then mark the item's final word.
         ST_DONE_FLUSH: begin
            if ((base_ff >= cfg.total_frames) && !done_sent_ff) begin
               if (ostat.room) begin
                  cmd.push      = 1'b1;
                  cmd.word.kind = KIND_DONE;
                  done_sent_in  = 1'b1;
               end
            end else begin
               cmd.flush = 1'b1;
               if (ostat.room) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_sent_ff <= 1'b0;
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         scan_slot_ff <= '0;
         k_ff         <= '0;
         time_ff      <= '0;
         acked_ff     <= '0;
         resent_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         done_sent_ff <= done_sent_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         scan_slot_ff <= scan_slot_in;
         k_ff         <= k_in;
         time_ff      <= time_in;
         acked_ff     <= acked_in;
         resent_ff    <= resent_in;
      end
      ack_ff <= ack_in;
   end

endmodule

[rtl/selective_repeat_sender_top.sv]
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    req_mode, req_ack_index
// rsp      out        rsp_valid/stall    rsp_kind, rsp_frame_index, rsp_rtt_ms, rsp_last
// csr      in/out     psel/penable       window_size 0x0, total_frames 0x4, timeout_ms 0x8
//
// One item at a time. Each unacked outstanding slot that a tick visits is read from the
// registered send-time memory before its age is evaluated.
// Reset is synchronous; a stalled rsp holds the controller only when a second word waits.
module selective_repeat_sender_top #(
   parameter int unsigned WINDOW_MAX = 8,
   parameter int unsigned TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_ack_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_frame_index,
   output logic [15:0] rsp_rtt_ms,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [srs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import srs_pkg::*;

   localparam int unsigned SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [3:0]           window_size_ff;
   logic [15:0]          total_frames_ff;
   logic [15:0]          timeout_ms_ff;
   logic [1:0]           csr_index;
   logic                 csr_write;
   srs_cfg_type          cfg;
   srs_cmd_type          cmd;
   srs_ostat_type        ostat;
   srs_word_type         rsp_word;
   logic                 ram_wr_en;
   logic [SW-1:0]        ram_wr_addr;
   logic [TIME_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [SW-1:0]        ram_rd_addr;
   logic [TIME_BITS-1:0] ram_rd_data;

   // Register port: writes land in the access phase, reads are combinational.
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= 4'd4;
         total_frames_ff <= 16'd1;
         timeout_ms_ff   <= 16'd1000;
      end else if (csr_write) begin
         case (csr_index)
            REG_WINDOW_SIZE:  window_size_ff  <= pwdata[3:0];
            REG_TOTAL_FRAMES: total_frames_ff <= pwdata[15:0];
            REG_TIMEOUT_MS:   timeout_ms_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WINDOW_SIZE:  prdata = 32'(window_size_ff);
         REG_TOTAL_FRAMES: prdata = 32'(total_frames_ff);
         REG_TIMEOUT_MS:   prdata = 32'(timeout_ms_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.window_size  = window_size_ff;
   assign cfg.total_frames = total_frames_ff;
   assign cfg.timeout_ms   = timeout_ms_ff;

   // Window sequencer with per-slot flags.
   srs_ctrl #(
      .WINDOW_MAX (WINDOW_MAX),
      .TIME_BITS  (TIME_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_ack_index (req_ack_index),
      .cfg           (cfg),
      .cmd           (cmd),
      .ostat         (ostat),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   // Send time of each window slot.
   srs_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_send_time (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pending word and output register.
   srs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ostat     (ostat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_kind        = rsp_word.kind;
   assign rsp_frame_index = rsp_word.frame_index;
   assign rsp_rtt_ms      = rsp_word.rtt_ms;
   assign rsp_last        = rsp_word.last;

endmodule

[tb/selective_repeat_sender_top_test.sv]
`timescale 1ns / 100ps

module selective_repeat_sender_top_test;
   import srs_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int SLOTS         = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 29;
   localparam int PLAN_ROWS     = 22;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_ACK  = 1'b1;
   localparam logic ROW_ITEM  = 1'b0;
   localparam logic ROW_CFG   = 1'b1;

   // Result words that can be read straight off the protocol.
   localparam srs_word_type NO_WORD      = '0;
   localparam srs_word_type W_SEND0_LAST = '{KIND_SEND, 16'd0, 16'd0, 1'b1};
   localparam srs_word_type W_RTT0       = '{KIND_RTT, 16'd0, 16'd0, 1'b0};
   localparam srs_word_type W_DONE_LAST  = '{KIND_DONE, 16'd0, 16'd0, 1'b1};

   // One row of the directed plan: an item, or a register write between items.
   typedef struct packed {
      logic         op;
      logic         mode;
      logic [15:0]  arg;
      logic [1:0]   reg_sel;
      logic [1:0]   n_fixed;
      srs_word_type word0;
      srs_word_type word1;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_ITEM, MODE_TICK, 16'h0000, REG_WINDOW_SIZE,  2'd1, W_SEND0_LAST, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0000, REG_WINDOW_SIZE,  2'd2, W_RTT0, W_DONE_LAST},
      '{ROW_ITEM, MODE_ACK,  16'hFFFF, REG_WINDOW_SIZE,  2'd1, W_DONE_LAST, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'h0000, REG_TIMEOUT_MS,   2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'h0000, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'hFFFF, REG_TOTAL_FRAMES, 2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_TICK, 16'hA5A5, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_TICK, 16'h5A5A, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0001, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0002, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'h000F, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'h0001, REG_TIMEOUT_MS,   2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_TICK, 16'h0000, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h000A, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h000A, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0004, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0003, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'hFFFF, REG_TIMEOUT_MS,   2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_TICK, 16'hFFFF, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD},
      '{ROW_CFG,  MODE_TICK, 16'h0000, REG_TOTAL_FRAMES, 2'd0, NO_WORD, NO_WORD},
      '{ROW_ITEM, MODE_TICK, 16'h0000, REG_WINDOW_SIZE,  2'd1, W_DONE_LAST, NO_WORD},
      '{ROW_ITEM, MODE_ACK,  16'h0005, REG_WINDOW_SIZE,  2'd0, NO_WORD, NO_WORD}
   };

   // Settings of the random phases.
   localparam logic [15:0] PHASE_WINDOW  [PHASES] = '{16'd8, 16'd15, 16'd3, 16'd1};
   localparam logic [15:0] PHASE_TIMEOUT [PHASES] = '{16'd6, 16'd4, 16'hFFFF, 16'd2};
   localparam logic [15:0] PHASE_SPAN    [PHASES] = '{16'd30, 16'd40, 16'd25, 16'd30};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_mode;
   logic [15:0]              req_ack_index;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_kind;
   logic [15:0]              rsp_frame_index;
   logic [15:0]              rsp_rtt_ms;
   logic                     rsp_last;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   // Predicted sender state and configuration.
   logic [3:0]   cfg_window;
   logic [15:0]  cfg_total;
   logic [15:0]  cfg_timeout;
   logic [15:0]  base_idx;
   logic [15:0]  next_idx;
   logic [31:0]  now_ticks;
   logic [31:0]  slot_sent_at [SLOTS];
   bit           slot_acked [SLOTS];
   bit           slot_resent [SLOTS];
   srs_word_type item_words [$];
   srs_word_type due_words [$];

   bit idle_enabled = 1'b1;
   bit hold_pending = 1'b0;
   int error_count = 0;
   int words_checked = 0;
   int config_writes = 0;
   int quiet_cycles = 0;
   int kind_seen [4];

   selective_repeat_sender_top dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_word(input logic [1:0] kind, input logic [15:0] idx,
                                    input logic [15:0] rtt);
      item_words.push_back('{kind, idx, rtt, 1'b0});
   endfunction

   // Advances the window for one item and leaves its result words in item_words.
   // Returns 0 for an acknowledgement that the sender ignores.
   function automatic bit window_step(input logic mode, input logic [15:0] ack);
      logic [15:0] cnt;
      logic [15:0] idx;
      logic [15:0] eff;
      logic [31:0] elapsed;
      int          s;
      bit          acted;
      item_words.delete();
      acted = 1'b1;
      if (mode == MODE_TICK) begin
         // Resend every unacknowledged frame whose timeout has run out.
         now_ticks = now_ticks + 32'd1;
         cnt = next_idx - base_idx;
         for (int k = 0; k < int'(cnt); k++) begin
            idx = base_idx + 16'(k);
            s = int'(idx) % SLOTS;
            if (!slot_acked[s]) begin
               elapsed = now_ticks - slot_sent_at[s];
               if (elapsed >= 32'(cfg_timeout)) begin
                  add_word(KIND_RESEND, idx, 16'd0);
                  slot_sent_at[s] = now_ticks;
                  slot_resent[s] = 1'b1;
               end
            end
         end
      end else begin
         // An acknowledgement inside the window marks its frame and slides the base.
         s = int'(ack) % SLOTS;
         if (16'(ack - base_idx) < 16'(next_idx - base_idx) && !slot_acked[s]) begin
            slot_acked[s] = 1'b1;
            // Resent frames give no round-trip sample.
            if (!slot_resent[s]) begin
               elapsed = now_ticks - slot_sent_at[s];
               add_word(KIND_RTT, ack, (elapsed > 32'(RTT_MAX)) ? RTT_MAX : elapsed[15:0]);
            end
            while (base_idx < cfg_total && base_idx != next_idx
                   && slot_acked[int'(base_idx) % SLOTS])
               base_idx = base_idx + 16'd1;
         end else begin
            acted = 1'b0;
         end
      end
      // Refill the window up to its saturated size.
      if (cfg_window == 4'd0)
         eff = 16'd1;
      else if (cfg_window > 4'(SLOTS))
         eff = 16'(SLOTS);
      else
         eff = {12'd0, cfg_window};
      while (next_idx < cfg_total && 16'(next_idx - base_idx) < eff) begin
         s = int'(next_idx) % SLOTS;
         slot_sent_at[s] = now_ticks;
         slot_acked[s] = 1'b0;
         slot_resent[s] = 1'b0;
         add_word(KIND_SEND, next_idx, 16'd0);
         next_idx = next_idx + 16'd1;
      end
      if (base_idx >= cfg_total) add_word(KIND_DONE, 16'd0, 16'd0);
      if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
      return acted;
   endfunction

   // Offers one item, waits until it is taken, and queues the words it should cause.
   task automatic send_item(input logic mode, input logic [15:0] ack,
                            input logic [1:0] n_fixed, input srs_word_type word0,
                            input srs_word_type word1, output bit acted);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_ack_index <= ack;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      acted = window_step(mode, ack);
      if (n_fixed == 2'd0) begin
         foreach (item_words[j]) due_words.push_back(item_words[j]);
      end else begin
         due_words.push_back(word0);
         if (n_fixed == 2'd2) due_words.push_back(word1);
      end
   endtask

   // Waits until every expected word has come, then lets a late item finish.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, then a read back of the same register.
   task automatic write_register(input logic [1:0] reg_sel, input logic [15:0] value);
      logic [31:0] stored;
      stored = (reg_sel == REG_WINDOW_SIZE) ? {28'd0, value[3:0]} : {16'd0, value};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (reg_sel)
         REG_WINDOW_SIZE:  cfg_window  = value[3:0];
         REG_TOTAL_FRAMES: cfg_total   = value;
         REG_TIMEOUT_MS:   cfg_timeout = value;
         default: ;
      endcase
      config_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== stored)
         report_error($sformatf("register %0d reads %h, expected %h", reg_sel, prdata, stored));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result checker: each word taken is compared with the oldest expected word.
   always @(posedge clock) begin
      srs_word_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_words.size() == 0) begin
            report_error($sformatf("unexpected word kind %0d frame %0d",
                                   rsp_kind, rsp_frame_index));
         end else begin
            want = due_words.pop_front();
            words_checked++;
            kind_seen[want.kind]++;
            if (rsp_kind !== want.kind)
               report_error($sformatf("kind %0d, expected %0d (frame %0d)",
                                      rsp_kind, want.kind, want.frame_index));
            if (rsp_frame_index !== want.frame_index)
               report_error($sformatf("frame %0d, expected %0d (kind %0d)",
                                      rsp_frame_index, want.frame_index, want.kind));
            if (rsp_rtt_ms !== want.rtt_ms)
               report_error($sformatf("rtt %0d, expected %0d (frame %0d)",
                                      rsp_rtt_ms, want.rtt_ms, want.frame_index));
            if (rsp_last !== want.last)
               report_error($sformatf("last %b, expected %b (frame %0d)",
                                      rsp_last, want.last, want.frame_index));
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d quiet cycles, %0d words still due",
                     quiet_cycles, due_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Result side stalls at random, and once holds off for a long stretch.
   initial begin
      int n;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   // Stimulus: directed plan, then random phases with different settings.
   initial begin
      plan_row_type row;
      bit          acted;
      logic        mode;
      logic [15:0] ack;
      int          counted;
      int          out_cnt;
      int          r;
      int          directed_items;
      int          random_items;
      int          ignored_items;
      directed_items = 0;
      random_items   = 0;
      ignored_items  = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= MODE_TICK;
      req_ack_index <= 16'd0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= 32'd0;

      // Predicted state after reset.
      cfg_window  = 4'd4;
      cfg_total   = 16'd1;
      cfg_timeout = 16'd1000;
      base_idx    = 16'd0;
      next_idx    = 16'd0;
      now_ticks   = 32'd0;
      for (int s = 0; s < SLOTS; s++) begin
         slot_sent_at[s] = 32'd0;
         slot_acked[s]   = 1'b0;
         slot_resent[s]  = 1'b0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed plan: saturated windows, zero and full timeouts, duplicates, completion.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = DIRECTED_PLAN[i];
         if (row.op == ROW_CFG) begin
            drain_results();
            write_register(row.reg_sel, row.arg);
         end else begin
            send_item(row.mode, row.arg, row.n_fixed, row.word0, row.word1, acted);
            directed_items++;
            if (!acted) ignored_items++;
         end
      end

      // Random phases: mostly acknowledgements of outstanding frames, some ticks,
      // and a share of stale, duplicate or wild acknowledgements.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_register(REG_WINDOW_SIZE, PHASE_WINDOW[p]);
         write_register(REG_TIMEOUT_MS, PHASE_TIMEOUT[p]);
         write_register(REG_TOTAL_FRAMES, next_idx + PHASE_SPAN[p]);
         idle_enabled = (p != 1);
         if (p == 1) hold_pending = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            out_cnt = int'(16'(next_idx - base_idx));
            mode = MODE_ACK;
            if (r < 30 || (r < 85 && out_cnt == 0)) begin
               mode = MODE_TICK;
               ack = 16'($urandom);
            end else if (r < 85) begin
               ack = base_idx + 16'($urandom_range(0, out_cnt - 1));
            end else if (r < 93) begin
               ack = base_idx - 16'($urandom_range(1, 4));
            end else begin
               ack = 16'($urandom);
            end
            send_item(mode, ack, 2'd0, NO_WORD, NO_WORD, acted);
            random_items++;
            counted++;
            if (!acted) ignored_items++;
         end
      end

      drain_results();
      if (due_words.size() != 0)
         report_error($sformatf("%0d expected words never came", due_words.size()));
      $display("Ran %0d directed and %0d random items (%0d ignored acknowledgements),",
               directed_items, random_items, ignored_items);
      $display("%0d register writes; %0d words checked.", config_writes, words_checked);
      $display("Words seen: %0d sends, %0d resends, %0d rtt samples, %0d completions; %0d errors.",
               kind_seen[KIND_SEND], kind_seen[KIND_RESEND], kind_seen[KIND_RTT],
               kind_seen[KIND_DONE], error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
